@@ hw/rtl/dt360_pkg.sv @@
// ----------------------------------------------------------------------------
// dt360_pkg: shared types, constants and helpers
// Constants of the 360-day calendar, reciprocal multipliers for the constant
// divisions, the records passed between pipeline stages, and the one-step
// carry/borrow helper used for every small calendar field.
// ----------------------------------------------------------------------------
package dt360_pkg;

  // Field moduli of the 360-day calendar.
  localparam logic [19:0] US_PER_S        = 20'd1000000;
  localparam logic [6:0]  S_PER_MIN       = 7'd60;
  localparam logic [6:0]  MIN_PER_HOUR    = 7'd60;
  localparam logic [6:0]  HOURS_PER_DAY   = 7'd24;
  localparam logic [6:0]  DAYS_PER_MONTH  = 7'd30;
  localparam logic [6:0]  MONTHS_PER_YEAR = 7'd12;

  // Days per year is 8 * 45: days / 360 = (days >> 3) * ceil(2^35 / 45) >> 35.
  // Exact for any shifted day count below 2^29.
  localparam logic [29:0] RECIP_45  = 30'd763549742;
  localparam int          SHIFT_45  = 35;

  // Seconds per hour is 16 * 225: secs / 3600 = (secs >> 4) * ceil(2^21 / 225) >> 21.
  localparam logic [13:0] RECIP_225 = 14'd9321;
  localparam int          SHIFT_225 = 21;

  // Division of a value below 360 by 30, and of a value below 3600 by 60.
  localparam logic [11:0] RECIP_30  = 12'd2185;
  localparam int          SHIFT_30  = 16;
  localparam logic [12:0] RECIP_60  = 13'd4370;
  localparam int          SHIFT_60  = 18;

  // Date-time fields that travel down the pipeline.
  typedef struct packed {
    logic        sub;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
    logic [19:0] micro;
    logic        us_c;
  } dt_fix_t;

  // Pieces of the time difference after the constant divisions.
  typedef struct packed {
    logic [5:0]  qh;  // hours of the difference
    logic [8:0]  ry;  // days left after whole years
    logic [11:0] rh;  // seconds left after whole hours
    logic [3:0]  mo;  // months of the difference
    logic [5:0]  mi;  // minutes of the difference
  } parts_t;

  // Result of one carry or borrow step.
  typedef struct packed {
    logic       carry;
    logic [7:0] val;
  } step_t;

  // Add or subtract one part plus an incoming carry, then correct once.
  function automatic step_t field_step(input logic [6:0] a, input logic [6:0] b,
                                       input logic cin, input logic sub,
                                       input logic [6:0] modulus);
    logic [9:0] v;
    step_t      r;
    if (!sub) begin
      v       = {3'b000, a} + {3'b000, b} + 10'(cin);
      r.carry = (v >= {3'b000, modulus});
      if (r.carry) begin
        v = v - {3'b000, modulus};
      end
    end else begin
      v       = {3'b000, a} - {3'b000, b} - 10'(cin);
      r.carry = v[9];
      if (r.carry) begin
        v = v + {3'b000, modulus};
      end
    end
    r.val = v[7:0];
    return r;
  endfunction

endpackage

@@ hw/rtl/dt360_split.sv @@
// ----------------------------------------------------------------------------
// dt360_split: time difference decomposition
// Three register stages. The first multiplies by reciprocals to get whole
// years and whole hours of the difference and settles the microsecond
// field; the second forms the remainders; the third splits them into months
// and minutes.
// ----------------------------------------------------------------------------
module dt360_split #(
  parameter int YEAR_BITS      = 16,
  parameter int DELTA_DAY_BITS = 20,
  localparam int QY_BITS       = DELTA_DAY_BITS - 8
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      adv,
  input  logic                      in_valid,
  input  dt360_pkg::dt_fix_t        fix_in,
  input  logic [YEAR_BITS-1:0]      year_in,
  input  logic [DELTA_DAY_BITS-1:0] delta_days,
  input  logic [16:0]               delta_secs,
  input  logic [19:0]               delta_micros,
  output logic                      vld,
  output dt360_pkg::dt_fix_t        fix,
  output logic [YEAR_BITS-1:0]      year,
  output logic [QY_BITS-1:0]        qy,
  output dt360_pkg::parts_t         parts
);
  import dt360_pkg::*;

  localparam int PROD_BITS = DELTA_DAY_BITS + 27;

  // Stage 1 registers.
  logic                 s1_vld;
  dt_fix_t              s1_fix;
  logic [YEAR_BITS-1:0] s1_year;
  logic [8:0]           s1_dd;
  logic [11:0]          s1_ds;
  logic [QY_BITS-1:0]   s1_qy;
  logic [5:0]           s1_qh;

  // Stage 2 registers.
  logic                 s2_vld;
  dt_fix_t              s2_fix;
  logic [YEAR_BITS-1:0] s2_year;
  logic [QY_BITS-1:0]   s2_qy;
  logic [5:0]           s2_qh;
  logic [8:0]           s2_ry;
  logic [11:0]          s2_rh;

  // Stage 1 logic: reciprocal products and the microsecond step.
  logic [PROD_BITS-1:0] day_prod;
  logic [26:0]          hr_prod;
  logic [21:0]          us_sum;
  logic                 us_c;
  dt_fix_t              fix_next;

  always_comb begin
    day_prod = PROD_BITS'(delta_days[DELTA_DAY_BITS-1:3]) * PROD_BITS'(RECIP_45);
    hr_prod  = 27'(delta_secs[16:4]) * 27'(RECIP_225);
    fix_next = fix_in;
    if (!fix_in.sub) begin
      us_sum = 22'(fix_in.micro) + 22'(delta_micros);
      us_c   = (us_sum >= 22'(US_PER_S));
      if (us_c) begin
        us_sum = us_sum - 22'(US_PER_S);
      end
    end else begin
      us_sum = 22'(fix_in.micro) - 22'(delta_micros);
      us_c   = us_sum[21];
      if (us_c) begin
        us_sum = us_sum + 22'(US_PER_S);
      end
    end
    fix_next.micro = us_sum[19:0];
    fix_next.us_c  = us_c;
  end

  // Stage 2 logic: remainders, exact in the low bits since they stay small.
  logic [8:0]  ry_next;
  logic [11:0] rh_next;

  always_comb begin
    ry_next = s1_dd - 9'(s1_qy) * 9'd360;
    rh_next = s1_ds - 12'(s1_qh) * 12'd3600;
  end

  // Stage 3 logic: months and minutes from the remainders.
  logic [20:0] mo_prod;
  logic [24:0] mi_prod;

  always_comb begin
    mo_prod = 21'(s2_ry) * 21'(RECIP_30);
    mi_prod = 25'(s2_rh) * 25'(RECIP_60);
  end

  // Valid bits advance with the pipeline.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld <= 1'b0;
      s2_vld <= 1'b0;
      vld    <= 1'b0;
    end else if (adv) begin
      s1_vld <= in_valid;
      s2_vld <= s1_vld;
      vld    <= s2_vld;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (adv) begin
      s1_fix   <= fix_next;
      s1_year  <= year_in;
      s1_dd    <= delta_days[8:0];
      s1_ds    <= delta_secs[11:0];
      s1_qy    <= day_prod[SHIFT_45 +: QY_BITS];
      s1_qh    <= hr_prod[SHIFT_225 +: 6];

      s2_fix   <= s1_fix;
      s2_year  <= s1_year;
      s2_qy    <= s1_qy;
      s2_qh    <= s1_qh;
      s2_ry    <= ry_next;
      s2_rh    <= rh_next;

      fix      <= s2_fix;
      year     <= s2_year;
      qy       <= s2_qy;
      parts.qh <= s2_qh;
      parts.ry <= s2_ry;
      parts.rh <= s2_rh;
      parts.mo <= mo_prod[SHIFT_30 +: 4];
      parts.mi <= mi_prod[SHIFT_60 +: 6];
    end
  end

endmodule

@@ hw/rtl/dt360_carry.sv @@
// ----------------------------------------------------------------------------
// dt360_carry: carry and borrow chain
// Three register stages. Seconds and minutes first, then hours, days and
// months, then the year sum with its overflow test. The last stage is the
// output register.
// ----------------------------------------------------------------------------
module dt360_carry #(
  parameter int YEAR_BITS      = 16,
  parameter int DELTA_DAY_BITS = 20,
  localparam int QY_BITS       = DELTA_DAY_BITS - 8
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 adv,
  input  logic                 vld_in,
  input  dt360_pkg::dt_fix_t   fix_in,
  input  logic [YEAR_BITS-1:0] year_in,
  input  logic [QY_BITS-1:0]   qy_in,
  input  dt360_pkg::parts_t    parts_in,
  output logic                 out_valid,
  output logic [YEAR_BITS-1:0] year_out,
  output logic [3:0]           month_out,
  output logic [4:0]           day_out,
  output logic [4:0]           hour_out,
  output logic [5:0]           minute_out,
  output logic [5:0]           second_out,
  output logic [19:0]          micro_out,
  output logic                 year_overflow
);
  import dt360_pkg::*;

  localparam int WB = ((YEAR_BITS > QY_BITS) ? YEAR_BITS : QY_BITS) + 2;

  // Stage 4 registers.
  logic                 s4_vld;
  dt_fix_t              s4_fix;
  logic                 s4_c;
  logic [YEAR_BITS-1:0] s4_year;
  logic [QY_BITS-1:0]   s4_qy;
  logic [5:0]           s4_qh;
  logic [4:0]           s4_dm;
  logic [3:0]           s4_mo;

  // Stage 5 registers.
  logic                 s5_vld;
  dt_fix_t              s5_fix;
  logic                 s5_c;
  logic [YEAR_BITS-1:0] s5_year;
  logic [QY_BITS-1:0]   s5_qy;

  // Stage 4 logic: last remainders, then seconds and minutes.
  logic [5:0] sd;
  logic [4:0] dm;
  step_t      sec_st;
  step_t      min_st;
  dt_fix_t    s4_fix_next;

  always_comb begin
    sd     = parts_in.rh[5:0] - parts_in.mi * 6'd60;
    dm     = parts_in.ry[4:0] - 5'(parts_in.mo) * 5'd30;
    sec_st = field_step(7'(fix_in.second), 7'(sd), fix_in.us_c, fix_in.sub, S_PER_MIN);
    min_st = field_step(7'(fix_in.minute), 7'(parts_in.mi), sec_st.carry, fix_in.sub,
                        MIN_PER_HOUR);
    s4_fix_next        = fix_in;
    s4_fix_next.second = sec_st.val[5:0];
    s4_fix_next.minute = min_st.val[5:0];
  end

  // Stage 5 logic: hours, days and months.
  step_t   hr_st;
  step_t   day_st;
  step_t   mon_st;
  dt_fix_t s5_fix_next;

  always_comb begin
    hr_st  = field_step(7'(s4_fix.hour), 7'(s4_qh), s4_c, s4_fix.sub, HOURS_PER_DAY);
    day_st = field_step(7'(s4_fix.day), 7'(s4_dm), hr_st.carry, s4_fix.sub, DAYS_PER_MONTH);
    mon_st = field_step(7'(s4_fix.month), 7'(s4_mo), day_st.carry, s4_fix.sub,
                        MONTHS_PER_YEAR);
    s5_fix_next       = s4_fix;
    s5_fix_next.hour  = hr_st.val[4:0];
    s5_fix_next.day   = day_st.val[4:0];
    s5_fix_next.month = mon_st.val[3:0];
  end

  // Stage 6 logic: year sum in a wide word; overflow when the bits above the
  // year's sign bit do not all match it.
  logic [WB-1:0]           yw;
  logic [WB-YEAR_BITS:0]   ytop;

  always_comb begin
    if (!s5_fix.sub) begin
      yw = {{(WB-YEAR_BITS){s5_year[YEAR_BITS-1]}}, s5_year} + WB'(s5_c) + WB'(s5_qy);
    end else begin
      yw = {{(WB-YEAR_BITS){s5_year[YEAR_BITS-1]}}, s5_year} - WB'(s5_c) - WB'(s5_qy);
    end
    ytop = yw[WB-1:YEAR_BITS-1];
  end

  // Valid bits advance with the pipeline.
  always_ff @(posedge clk) begin
    if (rst) begin
      s4_vld    <= 1'b0;
      s5_vld    <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      s4_vld    <= vld_in;
      s5_vld    <= s4_vld;
      out_valid <= s5_vld;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (adv) begin
      s4_fix        <= s4_fix_next;
      s4_c          <= min_st.carry;
      s4_year       <= year_in;
      s4_qy         <= qy_in;
      s4_qh         <= parts_in.qh;
      s4_dm         <= dm;
      s4_mo         <= parts_in.mo;

      s5_fix        <= s5_fix_next;
      s5_c          <= mon_st.carry;
      s5_year       <= s4_year;
      s5_qy         <= s4_qy;

      year_out      <= yw[YEAR_BITS-1:0];
      year_overflow <= !((&ytop) || !(|ytop));
      month_out     <= s5_fix.month;
      day_out       <= s5_fix.day;
      hour_out      <= s5_fix.hour;
      minute_out    <= s5_fix.minute;
      second_out    <= s5_fix.second;
      micro_out     <= s5_fix.micro;
    end
  end

endmodule

@@ hw/rtl/calendar360_timedelta_add_sub.sv @@
// ----------------------------------------------------------------------------
// calendar360_timedelta_add_sub: 360-day calendar date-time plus/minus delta
//
//   Channel  Handshake            Contents
//   in       in_valid/in_ready    func, start date-time, delta days/secs/micros
//   out      out_valid/out_ready  result date-time, year_overflow
//
// One word is accepted per cycle while in_ready is high; each result passes
// through six register stages (three for splitting the delta, three for the
// carry chain, the last being the output register).
// All stages advance together whenever the output register is empty or being
// read, so a stalled result holds the whole pipeline without loss.
// Synchronous reset clears the valid bits only; no warm-up is needed.
// ----------------------------------------------------------------------------
module calendar360_timedelta_add_sub #(
  parameter int YEAR_BITS      = 16,
  parameter int DELTA_DAY_BITS = 20
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic                      func,
  input  logic [YEAR_BITS-1:0]      year_in,
  input  logic [3:0]                month_in,
  input  logic [4:0]                day_in,
  input  logic [4:0]                hour_in,
  input  logic [5:0]                minute_in,
  input  logic [5:0]                second_in,
  input  logic [19:0]               micro_in,
  input  logic [DELTA_DAY_BITS-1:0] delta_days,
  input  logic [16:0]               delta_secs,
  input  logic [19:0]               delta_micros,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [YEAR_BITS-1:0]      year_out,
  output logic [3:0]                month_out,
  output logic [4:0]                day_out,
  output logic [4:0]                hour_out,
  output logic [5:0]                minute_out,
  output logic [5:0]                second_out,
  output logic [19:0]               micro_out,
  output logic                      year_overflow
);
  import dt360_pkg::*;

  localparam int QY_BITS = DELTA_DAY_BITS - 8;

  logic                 adv;
  dt_fix_t              fix_in;
  logic                 mid_vld;
  dt_fix_t              mid_fix;
  logic [YEAR_BITS-1:0] mid_year;
  logic [QY_BITS-1:0]   mid_qy;
  parts_t               mid_parts;

  // The pipeline moves whenever the output register can take a word.
  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;

  // Gather the start date-time fields.
  always_comb begin
    fix_in.sub    = func;
    fix_in.month  = month_in;
    fix_in.day    = day_in;
    fix_in.hour   = hour_in;
    fix_in.minute = minute_in;
    fix_in.second = second_in;
    fix_in.micro  = micro_in;
    fix_in.us_c   = 1'b0;
  end

  // Delta decomposition.
  dt360_split #(
    .YEAR_BITS      (YEAR_BITS),
    .DELTA_DAY_BITS (DELTA_DAY_BITS)
  ) u_split (
    .clk          (clk),
    .rst          (rst),
    .adv          (adv),
    .in_valid     (in_valid),
    .fix_in       (fix_in),
    .year_in      (year_in),
    .delta_days   (delta_days),
    .delta_secs   (delta_secs),
    .delta_micros (delta_micros),
    .vld          (mid_vld),
    .fix          (mid_fix),
    .year         (mid_year),
    .qy           (mid_qy),
    .parts        (mid_parts)
  );

  // Carry chain and output register.
  dt360_carry #(
    .YEAR_BITS      (YEAR_BITS),
    .DELTA_DAY_BITS (DELTA_DAY_BITS)
  ) u_carry (
    .clk           (clk),
    .rst           (rst),
    .adv           (adv),
    .vld_in        (mid_vld),
    .fix_in        (mid_fix),
    .year_in       (mid_year),
    .qy_in         (mid_qy),
    .parts_in      (mid_parts),
    .out_valid     (out_valid),
    .year_out      (year_out),
    .month_out     (month_out),
    .day_out       (day_out),
    .hour_out      (hour_out),
    .minute_out    (minute_out),
    .second_out    (second_out),
    .micro_out     (micro_out),
    .year_overflow (year_overflow)
  );

endmodule

@@ hw/rtl/dt360_checker.sv @@
// ----------------------------------------------------------------------------
// dt360_checker: port-level checks
// Watches the top level's handshakes and result word over time.
// ----------------------------------------------------------------------------
module dt360_checker #(
  parameter int YEAR_BITS = 16
) (
  input logic                 clk,
  input logic                 rst,
  input logic                 in_valid,
  input logic                 in_ready,
  input logic                 out_valid,
  input logic                 out_ready,
  input logic [YEAR_BITS-1:0] year_out,
  input logic [3:0]           month_out,
  input logic [4:0]           day_out,
  input logic [4:0]           hour_out,
  input logic [5:0]           minute_out,
  input logic [5:0]           second_out,
  input logic [19:0]          micro_out,
  input logic                 year_overflow
);

  // Reset leaves no result word pending.
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result word pending after reset");

  // Input side stays open whenever the output register can take a word.
  a_ready_when_free: assert property (@(posedge clk) disable iff (rst)
    (!out_valid || out_ready) |-> in_ready)
    else $error("input not ready while the pipeline can advance");

  // A stalled result word stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> out_valid)
    else $error("result word dropped while stalled");

  // A stalled result word keeps its contents.
  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> ($stable(year_out) && $stable(month_out) &&
      $stable(day_out) && $stable(hour_out) && $stable(minute_out) &&
      $stable(second_out) && $stable(micro_out) && $stable(year_overflow)))
    else $error("result word changed while stalled");

endmodule

bind calendar360_timedelta_add_sub dt360_checker #(.YEAR_BITS(YEAR_BITS)) u_dt360_checker (.*);
